>>> rtl/sca_pkg.sv
// Package for the chunked slot allocator: sizes, field widths, mode and status codes,
// controller command type and address helpers. No dependencies.
`timescale 1ns / 1ps
package sca_pkg;

  localparam int MAX_CHUNKS      = 4;
  localparam int SLOTS_PER_CHUNK = 64;
  localparam int TOTAL_SLOTS     = MAX_CHUNKS * SLOTS_PER_CHUNK;

  localparam int MODE_W   = 2;
  localparam int HANDLE_W = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;
  localparam int CNT_W    = $clog2(TOTAL_SLOTS + 1);
  localparam int CHUNK_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int SLOT_W   = $clog2(SLOTS_PER_CHUNK);
  localparam int DEPTH_W  = $clog2(SLOTS_PER_CHUNK + 1);
  localparam int ADDR_W   = $clog2(TOTAL_SLOTS);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CHUNK_W-1:0] c,
                                                  input logic [SLOT_W-1:0] s);
    return ADDR_W'((int'(c) * SLOTS_PER_CHUNK) + int'(s));
  endfunction

  function automatic logic [DEPTH_W-1:0] clamp_slots(input logic [CFG_W-1:0] v);
    logic [DEPTH_W-1:0] r;
    if (v == '0) begin
      r = DEPTH_W'(1);
    end else if (int'(v) > SLOTS_PER_CHUNK) begin
      r = DEPTH_W'(SLOTS_PER_CHUNK);
    end else begin
      r = DEPTH_W'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/sca_ctrl.sv
// Controller for the chunked slot allocator: two-state sequencer, load and execute commands,
// result strobe. Depends on sca_pkg.
`timescale 1ns / 1ps
module sca_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output sca_pkg::ctrl_cmd_t cmd,
  output logic               out_valid
);
  import sca_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  assign busy      = (state_r == S_EXEC);
  assign cmd.load  = start && (state_r == S_IDLE);
  assign cmd.exec  = (state_r == S_EXEC);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/sca_dp.sv
// Datapath for the chunked slot allocator: free-index stack and allocated-mark memories,
// chunk depths, live count, result registers. Depends on sca_pkg.
`timescale 1ns / 1ps
module sca_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sca_pkg::ctrl_cmd_t             cmd,
  input  logic [sca_pkg::MODE_W-1:0]     in_mode,
  input  logic [sca_pkg::HANDLE_W-1:0]   in_handle,
  input  logic                           cfg_we,
  input  logic [sca_pkg::CFG_W-1:0]      cfg_wdata,
  output logic [sca_pkg::STATUS_W-1:0]   out_status,
  output logic [sca_pkg::HANDLE_W-1:0]   out_granted_handle,
  output logic                           out_is_valid,
  output logic [sca_pkg::CNT_W-1:0]      out_live_count
);
  import sca_pkg::*;

  // storage
  logic [SLOT_W-1:0]      stk_mem [TOTAL_SLOTS];
  logic                   am_mem  [TOTAL_SLOTS];
  logic [DEPTH_W-1:0]     hw_r    [MAX_CHUNKS];
  logic [TOTAL_SLOTS-1:0] am_vld_r;
  logic [DEPTH_W-1:0]     depth_r [MAX_CHUNKS];
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic [DEPTH_W-1:0]     n_r;

  // item registers
  logic [MODE_W-1:0]  mode_r;
  logic [CHUNK_W-1:0] chunk_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               in_range_r;
  logic [ADDR_W-1:0]  h_addr_r;
  logic               alc_hit_r;
  logic [CHUNK_W-1:0] alc_chunk_r;
  logic [DEPTH_W-1:0] alc_depth_r;
  logic [SLOT_W-1:0]  stk_rd_r;
  logic               stk_vrd_r;
  logic               am_rd_r;
  logic               am_vrd_r;

  // result registers
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [HANDLE_W-1:0] granted_r, granted_nxt;
  logic                valid_r, valid_nxt;

  // load-side decode
  logic [HANDLE_W-1:0] h_chunk_full;
  logic [CHUNK_W-1:0]  h_chunk;
  logic [SLOT_W-1:0]   h_slot;
  logic                h_in_range;
  logic [ADDR_W-1:0]   h_addr;
  logic                alc_hit;
  logic [CHUNK_W-1:0]  alc_chunk;
  logic [ADDR_W-1:0]   stk_raddr;

  // execute-side controls
  logic               alloc_bit;
  logic [SLOT_W-1:0]  alc_slot;
  logic [DEPTH_W-1:0] free_depth;
  logic               stk_we;
  logic [ADDR_W-1:0]  stk_waddr;
  logic               am_set;
  logic               am_clr;
  logic [ADDR_W-1:0]  am_waddr;
  logic               dep_we;
  logic               hw_we;
  logic [CHUNK_W-1:0] dep_idx;
  logic [DEPTH_W-1:0] dep_val;
  logic               pool_clr;

  assign h_chunk_full = HANDLE_W'(in_handle / SLOTS_PER_CHUNK);
  assign h_chunk      = CHUNK_W'(h_chunk_full);
  assign h_slot       = SLOT_W'(in_handle % SLOTS_PER_CHUNK);
  assign h_in_range   = (int'(h_chunk_full) < MAX_CHUNKS) && (DEPTH_W'(h_slot) < n_r);
  assign h_addr       = slot_addr(h_chunk, h_slot);

  // first chunk with room
  always_comb begin
    alc_hit   = 1'b0;
    alc_chunk = '0;
    for (int c = MAX_CHUNKS - 1; c >= 0; c--) begin
      if (depth_r[c] < n_r) begin
        alc_hit   = 1'b1;
        alc_chunk = CHUNK_W'(c);
      end
    end
  end

  assign stk_raddr = slot_addr(alc_chunk, SLOT_W'(depth_r[alc_chunk]));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r      <= in_mode;
      chunk_r     <= h_chunk;
      slot_r      <= h_slot;
      in_range_r  <= h_in_range;
      h_addr_r    <= h_addr;
      alc_hit_r   <= alc_hit;
      alc_chunk_r <= alc_chunk;
      alc_depth_r <= depth_r[alc_chunk];
      stk_rd_r    <= stk_mem[stk_raddr];
      stk_vrd_r   <= (depth_r[alc_chunk] < hw_r[alc_chunk]);
      am_rd_r     <= am_mem[h_addr];
      am_vrd_r    <= am_vld_r[h_addr];
    end
    if (stk_we) stk_mem[stk_waddr] <= slot_r;
    if (am_set) am_mem[am_waddr] <= 1'b1;
  end

  assign alloc_bit  = am_vrd_r && am_rd_r;
  assign alc_slot   = stk_vrd_r ? stk_rd_r : SLOT_W'(alc_depth_r);
  assign free_depth = depth_r[chunk_r];

  always_comb begin
    status_nxt  = ST_OK;
    granted_nxt = '0;
    valid_nxt   = 1'b0;
    total_nxt   = total_r;
    stk_we      = 1'b0;
    stk_waddr   = slot_addr(chunk_r, SLOT_W'(free_depth - DEPTH_W'(1)));
    am_set      = 1'b0;
    am_clr      = 1'b0;
    am_waddr    = h_addr_r;
    dep_we      = 1'b0;
    hw_we       = 1'b0;
    dep_idx     = chunk_r;
    dep_val     = free_depth - DEPTH_W'(1);
    pool_clr    = 1'b0;
    if (cmd.exec) begin
      unique case (mode_r)
        MODE_ALLOC: begin
          if (alc_hit_r) begin
            am_set      = 1'b1;
            am_waddr    = slot_addr(alc_chunk_r, alc_slot);
            dep_we      = 1'b1;
            hw_we       = (alc_depth_r == hw_r[alc_chunk_r]);
            dep_idx     = alc_chunk_r;
            dep_val     = alc_depth_r + DEPTH_W'(1);
            total_nxt   = total_r + CNT_W'(1);
            granted_nxt = HANDLE_W'(slot_addr(alc_chunk_r, alc_slot));
          end else begin
            status_nxt = ST_FULL;
          end
        end
        MODE_FREE: begin
          if (!in_range_r) begin
            status_nxt = ST_RANGE;
          end else if (!alloc_bit || free_depth == '0) begin
            status_nxt = ST_NOT_ALLOC;
          end else begin
            am_clr = 1'b1;
            stk_we = 1'b1;
            dep_we = 1'b1;
            if (total_r != '0) total_nxt = total_r - CNT_W'(1);
          end
        end
        MODE_QUERY: begin
          if (!in_range_r) begin
            status_nxt = ST_RANGE;
          end else begin
            valid_nxt = alloc_bit;
          end
        end
        MODE_RESET: begin
          pool_clr  = 1'b1;
          total_nxt = '0;
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we || pool_clr) begin
      am_vld_r  <= '0;
      total_r   <= '0;
      for (int c = 0; c < MAX_CHUNKS; c++) begin
        depth_r[c] <= '0;
        hw_r[c]    <= '0;
      end
    end else begin
      if (am_set) am_vld_r[am_waddr] <= 1'b1;
      if (am_clr) am_vld_r[am_waddr] <= 1'b0;
      if (dep_we) depth_r[dep_idx] <= dep_val;
      if (hw_we) hw_r[dep_idx] <= dep_val;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= clamp_slots(CFG_RESET);
    end else if (cfg_we) begin
      n_r <= clamp_slots(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
      valid_r   <= valid_nxt;
    end
  end

  assign out_status         = status_r;
  assign out_granted_handle = granted_r;
  assign out_is_valid       = valid_r;
  assign out_live_count     = total_r;

endmodule

>>> rtl/chunked_slot_allocator.sv
// Chunked slot allocator top level: joins the sequencer and the datapath. Depends on sca_pkg.
// A word accepted with start is latched, executed while busy and its result registered with
// out_valid. No new word is taken while busy, owing to the registered read then write of the
// stack and mark memories. The receiver cannot stall; each result is flagged by out_valid
// for one cycle only. Reset, pool reset and a slots_in_use write clear all marks, depths and the
// live count through mark valid bits and a per-chunk stack high-water depth; no clearing pass.
`timescale 1ns / 1ps
module chunked_slot_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [sca_pkg::MODE_W-1:0]     in_mode,
  input  logic [sca_pkg::HANDLE_W-1:0]   in_handle,
  output logic                           out_valid,
  output logic [sca_pkg::STATUS_W-1:0]   out_status,
  output logic [sca_pkg::HANDLE_W-1:0]   out_granted_handle,
  output logic                           out_is_valid,
  output logic [sca_pkg::CNT_W-1:0]      out_live_count,
  input  logic                           cfg_we,
  input  logic [sca_pkg::CFG_W-1:0]      cfg_wdata
);
  import sca_pkg::*;

  ctrl_cmd_t cmd;

  sca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  sca_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_mode            (in_mode),
    .in_handle          (in_handle),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_status         (out_status),
    .out_granted_handle (out_granted_handle),
    .out_is_valid       (out_is_valid),
    .out_live_count     (out_live_count)
  );

endmodule

>>> rtl/sca_checker.sv
// Port-level checker for the chunked slot allocator, bound to the top level.
// Depends on sca_pkg.
`timescale 1ns / 1ps
module sca_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [sca_pkg::STATUS_W-1:0] out_status,
  input logic [sca_pkg::HANDLE_W-1:0] out_granted_handle,
  input logic                         out_is_valid
);
  import sca_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("busy cycle not followed by a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_granted_handle == '0)
    else $error("nonzero handle on failed word");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_valid |-> out_status == ST_OK)
    else $error("valid flag with error status");

endmodule

bind chunked_slot_allocator sca_checker u_sca_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_granted_handle (out_granted_handle),
  .out_is_valid       (out_is_valid)
);
